FILE: hdl/glyph_alpha_blit_rgb565_top_assert.svh
// Assertion macros used by the glyph blitter checker.
`ifndef GLYPH_ALPHA_BLIT_RGB565_TOP_ASSERT_SVH
`define GLYPH_ALPHA_BLIT_RGB565_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define GAB_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GAB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/gab_pkg.sv
// Shared constants, codes and types of the glyph blitter.
`default_nettype none
package gab_pkg;

    localparam int SCREEN_WIDTH    = 256;
    localparam int SCREEN_HEIGHT   = 256;
    localparam int GLYPH_SIDE_BITS = 8;

    localparam int FUNC_W    = 2;
    localparam int COORD_W   = 16;
    localparam int OFFS_W    = 8;
    localparam int SIDE_IN_W = 8;
    localparam int ALPHA_W   = 8;
    localparam int PIX_W     = 16;
    localparam int ADDR_W    = 16;

    localparam int SIDE_EXT_W  = (GLYPH_SIDE_BITS > SIDE_IN_W) ? GLYPH_SIDE_BITS : SIDE_IN_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int SX_W        = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int SY_W        = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func FUNC_HEADER = 2'd0;
    localparam t_func FUNC_SAMPLE = 2'd1;
    localparam t_func FUNC_READ   = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // One pixel operation handed from the front end to the back end.
    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  addr;
        logic [ALPHA_W-1:0] alpha;
        logic [PIX_W-1:0]   color;
    } t_bq_entry;

endpackage
`default_nettype wire

FILE: hdl/gab_front.sv
// Front end: accepts items, tracks the open glyph and queues pixel operations.
`default_nettype none
module gab_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [gab_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [gab_pkg::COORD_W-1:0]  i_pen_x,
    input  logic signed [gab_pkg::COORD_W-1:0]  i_baseline_y,
    input  logic signed [gab_pkg::OFFS_W-1:0]   i_offset_x,
    input  logic signed [gab_pkg::OFFS_W-1:0]   i_offset_y,
    input  logic [gab_pkg::SIDE_IN_W-1:0]       i_glyph_width,
    input  logic [gab_pkg::SIDE_IN_W-1:0]       i_glyph_height,
    input  logic [gab_pkg::PIX_W-1:0]           i_text_color,
    input  logic [gab_pkg::ALPHA_W-1:0]         i_alpha,
    input  logic [gab_pkg::ADDR_W-1:0]          i_read_address,
    input  logic                                i_queue_full,
    input  logic                                i_clearing,
    output logic                                o_push,
    output gab_pkg::t_bq_entry                  o_push_entry
);
    import gab_pkg::*;

    logic [COORD_W-1:0]         r_origin_x, n_origin_x;
    logic [COORD_W-1:0]         r_origin_y, n_origin_y;
    logic [GLYPH_SIDE_BITS-1:0] r_width, n_width;
    logic [GLYPH_SIDE_BITS-1:0] r_height, n_height;
    logic [GLYPH_SIDE_BITS-1:0] r_col, n_col;
    logic [GLYPH_SIDE_BITS-1:0] r_row, n_row;
    logic [PIX_W-1:0]           r_color, n_color;
    logic                       r_active, n_active;

    logic                       accept;
    logic [COORD_W-1:0]         hdr_origin_x;
    logic [COORD_W-1:0]         hdr_origin_y;
    logic [SIDE_EXT_W-1:0]      width_ext;
    logic [SIDE_EXT_W-1:0]      height_ext;
    logic [COORD_W-1:0]         px;
    logic [COORD_W-1:0]         py;
    logic                       on_screen;
    logic [31:0]                addr_full;
    logic [GLYPH_SIDE_BITS-1:0] col_inc;
    logic [GLYPH_SIDE_BITS-1:0] row_inc;

    assign o_stall = i_clearing || i_queue_full;
    assign accept  = i_valid && !o_stall;

    assign hdr_origin_x = COORD_W'(unsigned'(i_pen_x))
                        + {{(COORD_W-OFFS_W){i_offset_x[OFFS_W-1]}}, unsigned'(i_offset_x)};
    assign hdr_origin_y = COORD_W'(unsigned'(i_baseline_y))
                        + {{(COORD_W-OFFS_W){i_offset_y[OFFS_W-1]}}, unsigned'(i_offset_y)};
    assign width_ext    = SIDE_EXT_W'(i_glyph_width);
    assign height_ext   = SIDE_EXT_W'(i_glyph_height);

    // Pixel coordinates wrap at 16 bits and are then read as signed values.
    assign px = r_origin_x + COORD_W'(r_col);
    assign py = r_origin_y + COORD_W'(r_row);
    assign on_screen = !px[COORD_W-1] && (px < COORD_W'(SCREEN_WIDTH))
                    && !py[COORD_W-1] && (py < COORD_W'(SCREEN_HEIGHT));
    assign addr_full = 32'(py[SY_W-1:0]) * 32'(SCREEN_WIDTH) + 32'(px[SX_W-1:0]);

    assign col_inc = r_col + GLYPH_SIDE_BITS'(1);
    assign row_inc = r_row + GLYPH_SIDE_BITS'(1);

    always_comb begin
        n_origin_x   = r_origin_x;
        n_origin_y   = r_origin_y;
        n_width      = r_width;
        n_height     = r_height;
        n_col        = r_col;
        n_row        = r_row;
        n_color      = r_color;
        n_active     = r_active;
        o_push       = 1'b0;
        o_push_entry = '{kind: KIND_WRITE, addr: addr_full[ADDR_W-1:0],
                         alpha: i_alpha, color: r_color};
        if (accept) begin
            unique case (i_func)
                FUNC_HEADER: begin
                    n_origin_x = hdr_origin_x;
                    n_origin_y = hdr_origin_y;
                    n_width    = width_ext[GLYPH_SIDE_BITS-1:0];
                    n_height   = height_ext[GLYPH_SIDE_BITS-1:0];
                    n_color    = i_text_color;
                    n_col      = '0;
                    n_row      = '0;
                    n_active   = (width_ext[GLYPH_SIDE_BITS-1:0] != '0)
                              && (height_ext[GLYPH_SIDE_BITS-1:0] != '0);
                end
                FUNC_SAMPLE: begin
                    if (r_active) begin
                        o_push = (i_alpha != '0) && on_screen;
                        if (col_inc >= r_width) begin
                            n_col = '0;
                            if (row_inc >= r_height) begin
                                n_row    = '0;
                                n_active = 1'b0;
                            end else begin
                                n_row = row_inc;
                            end
                        end else begin
                            n_col = col_inc;
                        end
                    end
                end
                FUNC_READ: begin
                    o_push       = 1'b1;
                    o_push_entry = '{kind: KIND_READ, addr: i_read_address,
                                     alpha: i_alpha, color: r_color};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_color    <= '0;
            r_active   <= 1'b0;
        end else begin
            r_origin_x <= n_origin_x;
            r_origin_y <= n_origin_y;
            r_width    <= n_width;
            r_height   <= n_height;
            r_col      <= n_col;
            r_row      <= n_row;
            r_color    <= n_color;
            r_active   <= n_active;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/gab_queue.sv
// Short queue of pixel operations between the front end and the back end.
`default_nettype none
module gab_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gab_pkg::t_bq_entry i_push_entry,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_not_empty,
    output gab_pkg::t_bq_entry o_head
);
    import gab_pkg::*;

    t_bq_entry              r_slot [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_IDX_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;

    assign o_full      = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/gab_back.sv
// Back end: framebuffer, read-modify-write blend pipeline and result register.
`default_nettype none
module gab_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gab_pkg::t_bq_entry          i_head,
    input  logic                        i_not_empty,
    output logic                        o_pop,
    output logic                        o_clearing,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_kind,
    output logic [gab_pkg::ADDR_W-1:0]  o_pixel_address,
    output logic [gab_pkg::PIX_W-1:0]   o_pixel_value
);
    import gab_pkg::*;

    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'd255;

    // Floor division by 255, exact for the sums that one channel can reach.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] t;
        t = x + (x >> 8) + 16'd1;
        return t[15:8];
    endfunction

    function automatic logic [PIX_W-1:0] mix565(input logic [PIX_W-1:0] bg,
                                                input logic [PIX_W-1:0] fg,
                                                input logic [ALPHA_W-1:0] a);
        logic [ALPHA_W-1:0] ia;
        logic [15:0]        sr;
        logic [15:0]        sg;
        logic [15:0]        sb;
        logic [7:0]         qr;
        logic [7:0]         qg;
        logic [7:0]         qb;
        ia = ALPHA_FULL - a;
        sr = 16'(bg[15:11]) * 16'(ia) + 16'(fg[15:11]) * 16'(a);
        sg = 16'(bg[10:5]) * 16'(ia) + 16'(fg[10:5]) * 16'(a);
        sb = 16'(bg[4:0]) * 16'(ia) + 16'(fg[4:0]) * 16'(a);
        qr = div255(sr);
        qg = div255(sg);
        qb = div255(sb);
        return {qr[4:0], qg[5:0], qb[4:0]};
    endfunction

    logic [PIX_W-1:0]  r_frame [STORE_DEPTH];
    logic [PIX_W-1:0]  r_rdata;

    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              r_rd_valid;
    t_bq_entry         r_rd;

    logic              r_fw_en;
    logic [ADDR_W-1:0] r_fw_addr;
    logic [PIX_W-1:0]  r_fw_data;

    logic              r_out_valid;
    logic              r_out_kind;
    logic [ADDR_W-1:0] r_out_addr;
    logic [PIX_W-1:0]  r_out_value;

    logic              out_free;
    logic              rd_go;
    logic              rd_fire;
    logic              blend_wr;
    logic [PIX_W-1:0]  bg;
    logic [PIX_W-1:0]  blend;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;

    assign o_clearing      = r_clearing;
    assign o_valid         = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_pixel_address = r_out_addr;
    assign o_pixel_value   = r_out_value;

    assign out_free = !r_out_valid || !i_stall;
    assign rd_go    = !r_clearing && (!r_rd_valid || out_free);
    assign o_pop    = rd_go && i_not_empty;
    assign rd_fire  = r_rd_valid && out_free;
    assign blend_wr = rd_fire && (r_rd.kind == KIND_WRITE);

    // The write made at the edge that issued this read is not in the read data yet.
    assign bg    = (r_fw_en && (r_fw_addr == r_rd.addr)) ? r_fw_data : r_rdata;
    assign blend = mix565(bg, r_rd.color, r_rd.alpha);

    assign wr_en   = r_clearing || blend_wr;
    assign wr_addr = r_clearing ? r_clr_addr : r_rd.addr;
    assign wr_data = r_clearing ? '0 : blend;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_frame[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_rdata <= r_frame[i_head.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_rd_valid  <= 1'b0;
            r_fw_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            if (rd_go) begin
                r_rd_valid <= i_not_empty;
                r_fw_en    <= blend_wr;
            end
            if (out_free) begin
                r_out_valid <= r_rd_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_rd      <= i_head;
            r_fw_addr <= r_rd.addr;
            r_fw_data <= blend;
        end
        if (rd_fire) begin
            r_out_kind  <= r_rd.kind;
            r_out_addr  <= r_rd.addr;
            r_out_value <= (r_rd.kind == KIND_READ) ? bg : blend;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/glyph_alpha_blit_rgb565_top.sv
// Top level of the anti-aliased RGB565 glyph blitter.
//
// Input channel: i_valid/o_stall with one item per transfer. A header item (func 0)
// opens a glyph, alpha samples (func 1) follow in row-major order, and a read
// item (func 2) fetches one framebuffer pixel. Output channel: o_valid/i_stall
// carries one result per blended pixel write or per read.
// Throughput is one item per cycle while o_stall is low; each pixel takes a single
// read-modify-write pass of the framebuffer memory, with the previous write
// forwarded so that back-to-back hits on one address blend correctly.
// A result passes through the queue and the read stage to the result register.
// After reset the block clears all 65536 framebuffer entries, one per cycle,
// and holds o_stall high while the clear runs.
// A stalled result holds its payload. A queue of four operations sits
// between the front end and the blend pipeline, so input transfers go on
// while the receiver stalls until that queue fills, then o_stall rises.
`default_nettype none
module glyph_alpha_blit_rgb565_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [gab_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [gab_pkg::COORD_W-1:0]  i_pen_x,
    input  logic signed [gab_pkg::COORD_W-1:0]  i_baseline_y,
    input  logic signed [gab_pkg::OFFS_W-1:0]   i_offset_x,
    input  logic signed [gab_pkg::OFFS_W-1:0]   i_offset_y,
    input  logic [gab_pkg::SIDE_IN_W-1:0]       i_glyph_width,
    input  logic [gab_pkg::SIDE_IN_W-1:0]       i_glyph_height,
    input  logic [gab_pkg::PIX_W-1:0]           i_text_color,
    input  logic [gab_pkg::ALPHA_W-1:0]         i_alpha,
    input  logic [gab_pkg::ADDR_W-1:0]          i_read_address,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_kind,
    output logic [gab_pkg::ADDR_W-1:0]          o_pixel_address,
    output logic [gab_pkg::PIX_W-1:0]           o_pixel_value
);
    import gab_pkg::*;

    logic      push;
    t_bq_entry push_entry;
    logic      pop;
    logic      queue_full;
    logic      queue_not_empty;
    t_bq_entry queue_head;
    logic      clearing;

    gab_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_pen_x        (i_pen_x),
        .i_baseline_y   (i_baseline_y),
        .i_offset_x     (i_offset_x),
        .i_offset_y     (i_offset_y),
        .i_glyph_width  (i_glyph_width),
        .i_glyph_height (i_glyph_height),
        .i_text_color   (i_text_color),
        .i_alpha        (i_alpha),
        .i_read_address (i_read_address),
        .i_queue_full   (queue_full),
        .i_clearing     (clearing),
        .o_push         (push),
        .o_push_entry   (push_entry)
    );

    gab_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_full       (queue_full),
        .o_not_empty  (queue_not_empty),
        .o_head       (queue_head)
    );

    gab_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (queue_head),
        .i_not_empty     (queue_not_empty),
        .o_pop           (pop),
        .o_clearing      (clearing),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value)
    );

endmodule
`default_nettype wire

FILE: hdl/gab_checker.sv
// Port-level checks on the glyph blitter, bound to its top level.
`default_nettype none
`include "glyph_alpha_blit_rgb565_top_assert.svh"
module gab_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_stall,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic                        o_kind,
    input  logic [gab_pkg::ADDR_W-1:0]  o_pixel_address,
    input  logic [gab_pkg::PIX_W-1:0]   o_pixel_value
);

    // A result that the receiver stalls must stay as it is.
    `GAB_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_pixel_address) && $stable(o_pixel_value), "stalled result changed")

    // Reset starts the framebuffer clear, which refuses input transfers.
    `GAB_ASSERT_ALWAYS(a_rst_stall, i_clk, !i_rst_n |=> o_stall, "input not stalled after reset")

    // Reset empties the result register.
    `GAB_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind glyph_alpha_blit_rgb565_top gab_checker u_gab_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_kind          (o_kind),
    .o_pixel_address (o_pixel_address),
    .o_pixel_value   (o_pixel_value)
);
`default_nettype wire
